### rtl/core/sha1_pkg.sv
// Shared types and constants for the SHA-1 hasher.
`timescale 1ns / 1ps
`default_nettype none

package sha1_pkg;

   typedef struct packed {
      logic [31:0] data_word;
      logic [2:0]  byte_count;
      logic        last;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic        digest_last;
   } rsp_type;

   // Five 32-bit words: chaining values or working variables, index 0 = H0 / a.
   typedef logic [4:0][31:0] word5_type;

   // Control from the sequencer to the round unit.
   typedef struct packed {
      logic        start;   // load working vars and run 80 rounds
      logic        shift;   // push word into the schedule window
      logic [31:0] word;
   } rnd_ctrl_type;

   localparam logic [31:0] K_ROUND0 = 32'h5A82_7999;
   localparam logic [31:0] K_ROUND1 = 32'h6ED9_EBA1;
   localparam logic [31:0] K_ROUND2 = 32'h8F1B_BCDC;
   localparam logic [31:0] K_ROUND3 = 32'hCA62_C1D6;
   localparam logic [31:0] PAD_WORD = 32'h8000_0000;

   localparam word5_type INIT_VALUES = {
      32'hC3D2_E1F0, 32'h1032_5476, 32'h98BA_DCFE, 32'hEFCD_AB89, 32'h6745_2301
   };

   localparam logic [6:0] SCHED_ROUNDS = 7'd16;
   localparam logic [6:0] ROUND_20     = 7'd20;
   localparam logic [6:0] ROUND_40     = 7'd40;
   localparam logic [6:0] ROUND_60     = 7'd60;
   localparam logic [6:0] LAST_ROUND   = 7'd79;

endpackage

`default_nettype wire

### rtl/core/sha1_round.sv
// SHA-1 round unit: schedule window plus one compression round per cycle.
`timescale 1ns / 1ps
`default_nettype none

module sha1_round (
   input  logic                   clock,
   input  logic                   reset,
   input  sha1_pkg::rnd_ctrl_type ctrl,
   input  sha1_pkg::word5_type    cv,
   output sha1_pkg::word5_type    vars,
   output logic                   done
);
   import sha1_pkg::*;

   logic [15:0][31:0] win_ff, win_in;
   word5_type         vars_ff, vars_in;
   logic [6:0]        rnd_ff, rnd_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;

   logic [31:0] mix, wr, f, k, t;
   logic [31:0] a, b, c, d, e;

   always_comb begin
      a = vars_ff[0];
      b = vars_ff[1];
      c = vars_ff[2];
      d = vars_ff[3];
      e = vars_ff[4];

      // window slot 0 holds w[t-16]; taps 2, 8, 13 give w[t-14], w[t-8], w[t-3]
      mix = win_ff[13] ^ win_ff[8] ^ win_ff[2] ^ win_ff[0];
      wr  = (rnd_ff < SCHED_ROUNDS) ? win_ff[0] : {mix[30:0], mix[31]};

      if (rnd_ff < ROUND_20) begin
         f = (b & c) | (~b & d);
         k = K_ROUND0;
      end else if (rnd_ff < ROUND_40) begin
         f = b ^ c ^ d;
         k = K_ROUND1;
      end else if (rnd_ff < ROUND_60) begin
         f = (b & c) | (b & d) | (c & d);
         k = K_ROUND2;
      end else begin
         f = b ^ c ^ d;
         k = K_ROUND3;
      end

      t = {a[26:0], a[31:27]} + f + e + k + wr;

      win_in  = win_ff;
      vars_in = vars_ff;
      rnd_in  = rnd_ff;
      busy_in = busy_ff;
      done_in = 1'b0;

      if (ctrl.shift) begin
         win_in = {ctrl.word, win_ff[15:1]};
      end else if (busy_ff) begin
         win_in = {wr, win_ff[15:1]};
      end

      if (ctrl.start) begin
         vars_in = cv;
         rnd_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         vars_in = {d, c, {b[1:0], b[31:2]}, a, t};
         rnd_in  = rnd_ff + 7'd1;
         if (rnd_ff == LAST_ROUND) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rnd_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         rnd_ff  <= rnd_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      win_ff  <= win_in;
      vars_ff <= vars_in;
   end

   assign vars = vars_ff;
   assign done = done_ff;

endmodule

`default_nettype wire

### rtl/core/sha1_hash.sv
// SHA-1 hasher top level: input sequencer, padding, chaining values, digest output.
`timescale 1ns / 1ps
`default_nettype none

// Hashes one message at a time with SHA-1. Each request carries a big-endian
// 32-bit word; words that are not last count four bytes, the last word counts
// byte_count bytes (values above four count as four) left-justified in the word.
// Words are absorbed one per cycle into a 16-word schedule window while
// req_ready is high. The 16th word of a block starts the round unit, which runs
// the 80 SHA-1 rounds at one per cycle, then raises a registered done flag; the
// sequencer then adds the result into the chaining values. Throughput is set by
// the single round unit, and req_ready is low while the round unit is busy.
// On a last word the sequencer appends the 0x80 pad, zero fill and the 64-bit
// bit length one word per cycle, pausing while the round unit runs (one or
// two compressions), then presents the five digest words H0..H4 on rsp_*,
// digest_last on H4. After H4 is taken the chaining values are reloaded and
// the next message may start. The bit length wraps modulo 2^64.
module sha1_hash (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  sha1_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output sha1_pkg::rsp_type rsp_data
);
   import sha1_pkg::*;

   // sequencer states
   localparam logic [2:0] ST_IDLE  = 3'd0;  // taking message words
   localparam logic [2:0] ST_FEED  = 3'd1;  // generating pad / length words
   localparam logic [2:0] ST_ROUND = 3'd2;  // round unit running
   localparam logic [2:0] ST_ADD   = 3'd3;  // fold working vars into chaining values
   localparam logic [2:0] ST_OUT   = 3'd4;  // presenting digest words

   // padding phases
   localparam logic [1:0] PH_PAD  = 2'd0;  // full last word: 0x80 pad word next
   localparam logic [1:0] PH_FILL = 2'd1;  // zero fill, then length high word
   localparam logic [1:0] PH_LO   = 2'd2;  // length low word
   localparam logic [1:0] PH_DONE = 2'd3;  // final block queued

   localparam logic [2:0] LAST_IDX = 3'd4;

   logic [2:0]  state_ff, state_in;
   logic [1:0]  phase_ff, phase_in;
   logic        finish_ff, finish_in;
   logic [3:0]  pos_ff, pos_in;
   logic [63:0] bits_ff, bits_in;
   word5_type   cv_ff, cv_in;
   logic [2:0]  out_idx_ff, out_idx_in;

   logic         req_fire, rsp_fire;
   logic         put, start;
   logic [31:0]  put_word;
   logic [2:0]   count_sat;
   logic [4:0]   sh;
   logic [31:0]  keep, tail_word;
   word5_type    vars;
   logic         rnd_done;
   rnd_ctrl_type rnd_ctrl;

   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;

   // Final word: keep the valid bytes and insert the pad byte right below them.
   assign count_sat = (req_data.byte_count > 3'd4) ? 3'd4 : req_data.byte_count;
   assign sh        = {count_sat[1:0], 3'b000};
   assign keep      = ~(32'hFFFF_FFFF >> sh);
   assign tail_word = (count_sat == 3'd4) ? req_data.data_word
                                          : ((req_data.data_word & keep) | (PAD_WORD >> sh));

   always_comb begin
      state_in   = state_ff;
      phase_in   = phase_ff;
      finish_in  = finish_ff;
      pos_in     = pos_ff;
      bits_in    = bits_ff;
      cv_in      = cv_ff;
      out_idx_in = out_idx_ff;
      put        = 1'b0;
      put_word   = req_data.data_word;
      start      = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               put = 1'b1;
               if (req_data.last) begin
                  put_word  = tail_word;
                  bits_in   = bits_ff + {58'd0, count_sat, 3'b000};
                  finish_in = 1'b1;
                  phase_in  = (count_sat == 3'd4) ? PH_PAD : PH_FILL;
                  state_in  = ST_FEED;
               end else begin
                  bits_in = bits_ff + 64'd32;
               end
            end
         end
         ST_FEED: begin
            put = 1'b1;
            unique case (phase_ff)
               PH_PAD: begin
                  put_word = PAD_WORD;
                  phase_in = PH_FILL;
               end
               PH_FILL: begin
                  // zero fill runs up to slot 14, where the length starts
                  if (pos_ff == 4'd14) begin
                     put_word = bits_ff[63:32];
                     phase_in = PH_LO;
                  end else begin
                     put_word = '0;
                  end
               end
               PH_LO: begin
                  put_word = bits_ff[31:0];
                  phase_in = PH_DONE;
               end
               default: begin
                  put = 1'b0;
               end
            endcase
         end
         ST_ROUND: begin
            if (rnd_done) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            for (int i = 0; i < 5; i++) begin
               cv_in[i] = cv_ff[i] + vars[i];
            end
            if (!finish_ff) begin
               state_in = ST_IDLE;
            end else if (phase_ff == PH_DONE) begin
               state_in = ST_OUT;
            end else begin
               state_in = ST_FEED;
            end
         end
         ST_OUT: begin
            if (rsp_fire) begin
               if (out_idx_ff == LAST_IDX) begin
                  out_idx_in = '0;
                  cv_in      = INIT_VALUES;
                  bits_in    = '0;
                  finish_in  = 1'b0;
                  state_in   = ST_IDLE;
               end else begin
                  out_idx_in = out_idx_ff + 3'd1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // every 16th word completes a block and kicks off the rounds
      if (put) begin
         pos_in = pos_ff + 4'd1;
         if (pos_ff == 4'd15) begin
            start    = 1'b1;
            state_in = ST_ROUND;
         end
      end
   end

   assign rnd_ctrl = '{start: start, shift: put, word: put_word};

   sha1_round u_round (
      .clock (clock),
      .reset (reset),
      .ctrl  (rnd_ctrl),
      .cv    (cv_ff),
      .vars  (vars),
      .done  (rnd_done)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         phase_ff   <= PH_PAD;
         finish_ff  <= 1'b0;
         pos_ff     <= '0;
         bits_ff    <= '0;
         cv_ff      <= INIT_VALUES;
         out_idx_ff <= '0;
      end else begin
         state_ff   <= state_in;
         phase_ff   <= phase_in;
         finish_ff  <= finish_in;
         pos_ff     <= pos_in;
         bits_ff    <= bits_in;
         cv_ff      <= cv_in;
         out_idx_ff <= out_idx_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);

   always_comb begin
      case (out_idx_ff)
         3'd0:    rsp_data.digest_word = cv_ff[0];
         3'd1:    rsp_data.digest_word = cv_ff[1];
         3'd2:    rsp_data.digest_word = cv_ff[2];
         3'd3:    rsp_data.digest_word = cv_ff[3];
         default: rsp_data.digest_word = cv_ff[4];
      endcase
      rsp_data.digest_last = (out_idx_ff == LAST_IDX);
   end

endmodule

`default_nettype wire

### rtl/core/sha1_chk.sv
// Port-level checker for the SHA-1 hasher, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module sha1_chk (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input sha1_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input sha1_pkg::rsp_type rsp_data
);
   import sha1_pkg::*;

   // never take a request while a digest is on offer
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("req_ready high while digest pending");

   // a last word always starts padding, so the input closes right after
   a_last_closes: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_data.last) |=> !req_ready)
      else $error("input still open after last request");

   // after H4 is taken the block returns to taking requests
   a_digest_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_data.digest_last) |=> (!rsp_valid && req_ready))
      else $error("block not idle after final digest word");

   // a stalled digest word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("digest word changed while stalled");

endmodule

bind sha1_hash sha1_chk u_sha1_chk (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire

### bench/tb_top.sv
// SHA-1 hasher testbench: predicts digests of random and corner-case messages.
`timescale 1ns / 1ps

module tb_top;

   // Test plan:
   //  - A directed set of short messages covers the empty message, each tail
   //    byte count from 0 to 7, ones below the valid tail bytes, junk byte
   //    counts on body words, and a tail that forces an extra padding block.
   //  - Random messages follow, mostly up to 17 words long and a few up to
   //    41 words, with random content, random tail counts and occasional
   //    all-zero or all-one fill.
   //  - A software model of SHA-1 runs on every accepted request. Each last
   //    word queues five digest words, which are checked in order against
   //    rsp_data.
   //  - Both sides insert random gaps of up to MAX_GAP, with some messages and
   //    digests run back to back. The receiver also blocks once for a long
   //    stretch so the hasher backs up, and the sender stops a few times until
   //    every digest is out.

   localparam int HALF_PERIOD  = 6;
   localparam int IDLE_LIMIT   = 3000;   // cycles with no handshake at all
   localparam int HOLD_CYCLES  = 400;    // one long receiver stall
   localparam int HOLD_AFTER   = 10;     // digest words taken before that stall
   localparam int RANDOM_ITEMS = 400;
   localparam int DRAIN_CYCLES = 250;    // more than two compressions plus output
   localparam int MAX_GAP      = 18;

   typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_kind_type;

   // Software SHA-1: running hash state plus the digest words still owed.
   class digest_tracker_type;
      localparam int MAX_REPORTS = 10;
      localparam logic [31:0] PAD_WORD = 32'h8000_0000;
      localparam logic [31:0] H_INIT [5] = '{
         32'h6745_2301, 32'hEFCD_AB89, 32'h98BA_DCFE, 32'h1032_5476, 32'hC3D2_E1F0
      };
      localparam logic [31:0] ROUND_K [4] = '{
         32'h5A82_7999, 32'h6ED9_EBA1, 32'h8F1B_BCDC, 32'hCA62_C1D6
      };

      logic [31:0] chain [5];
      logic [31:0] block_w [16];
      logic [3:0]  pos;
      logic [63:0] bits;
      sha1_pkg::rsp_type expected_digests [$];
      int unsigned mismatches;

      function new();
         mismatches = 0;
         restart();
         foreach (block_w[i]) block_w[i] = '0;
      endfunction

      function void restart();
         foreach (chain[i]) chain[i] = H_INIT[i];
         pos  = '0;
         bits = '0;
      endfunction

      function logic [31:0] rotl(logic [31:0] x, int unsigned s);
         return (x << s) | (x >> (32 - s));
      endfunction

      function void compress_block();
         logic [31:0] w [16];
         logic [31:0] a, b, c, d, e, f, k, t, wr;
         w = block_w;
         a = chain[0];
         b = chain[1];
         c = chain[2];
         d = chain[3];
         e = chain[4];
         for (int r = 0; r < 80; r++) begin
            if (r < 16) begin
               wr = w[r];
            end else begin
               wr = rotl(w[(r + 13) % 16] ^ w[(r + 8) % 16] ^ w[(r + 2) % 16] ^ w[r % 16], 1);
               w[r % 16] = wr;
            end
            if (r < 20) begin
               f = (b & c) | (~b & d);
               k = ROUND_K[0];
            end else if (r < 40) begin
               f = b ^ c ^ d;
               k = ROUND_K[1];
            end else if (r < 60) begin
               f = (b & c) | (b & d) | (c & d);
               k = ROUND_K[2];
            end else begin
               f = b ^ c ^ d;
               k = ROUND_K[3];
            end
            t = rotl(a, 5) + f + e + k + wr;
            e = d;
            d = c;
            c = rotl(b, 30);
            b = a;
            a = t;
         end
         chain[0] += a;
         chain[1] += b;
         chain[2] += c;
         chain[3] += d;
         chain[4] += e;
      endfunction

      function void absorb(logic [31:0] word);
         block_w[pos] = word;
         pos = pos + 1'b1;
         if (pos == 0) compress_block();
      endfunction

      function void note_request(sha1_pkg::req_type item);
         int unsigned count;
         logic [31:0] keep;
         sha1_pkg::rsp_type digest;
         if (!item.last) begin
            bits += 64'd32;
            absorb(item.data_word);
            return;
         end
         count = (item.byte_count > 3'd4) ? 4 : item.byte_count;
         bits += 64'(8 * count);
         if (count == 4) begin
            absorb(item.data_word);
            absorb(PAD_WORD);
         end else begin
            keep = (count == 0) ? '0 : (32'hFFFF_FFFF << (32 - 8 * count));
            absorb((item.data_word & keep) | (PAD_WORD >> (8 * count)));
         end
         if (pos == 4'd15) absorb('0);
         while (pos < 4'd14) absorb('0);
         absorb(bits[63:32]);
         absorb(bits[31:0]);
         for (int j = 0; j < 5; j++) begin
            digest.digest_word = chain[j];
            digest.digest_last = (j == 4);
            expected_digests.push_back(digest);
         end
         restart();
      endfunction

      function void note_mismatch(string msg);
         mismatches++;
         if (mismatches <= MAX_REPORTS) $display("%0t ns: %s", $time, msg);
      endfunction

      function void check_digest(sha1_pkg::rsp_type got);
         sha1_pkg::rsp_type want;
         if (expected_digests.size() == 0) begin
            note_mismatch($sformatf("unexpected digest word %h last %b",
                                    got.digest_word, got.digest_last));
            return;
         end
         want = expected_digests.pop_front();
         if (got.digest_word !== want.digest_word)
            note_mismatch($sformatf("digest_word: expected %h, got %h",
                                    want.digest_word, got.digest_word));
         if (got.digest_last !== want.digest_last)
            note_mismatch($sformatf("digest_last: expected %b, got %b (word %h)",
                                    want.digest_last, got.digest_last, got.digest_word));
      endfunction

      function int unsigned pending();
         return expected_digests.size();
      endfunction
   endclass

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   sha1_pkg::req_type req_data  = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   sha1_pkg::rsp_type rsp_data;

   digest_tracker_type tracker;
   int unsigned        requests_sent = 0;
   int unsigned        idle_cycles   = 0;

   sha1_hash dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // Watchdog: any handshake clears the count; a long silence means a hang.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == IDLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic logic [31:0] fill_word(fill_kind_type fill);
      case (fill)
         FILL_ZERO: return 32'h0000_0000;
         FILL_ONES: return 32'hFFFF_FFFF;
         default:   return $urandom;
      endcase
   endfunction

   // Offers one request after an optional gap and returns once it is taken.
   // valid is only dropped when a gap follows, so back-to-back requests keep
   // it high across the accepting edge.
   task automatic send_request(sha1_pkg::req_type item, int unsigned gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      tracker.note_request(item);
      requests_sent++;
   endtask

   // Body words carry junk byte counts; the hasher must treat them as four bytes.
   task automatic send_message(int unsigned body_words, logic [2:0] tail_count,
                               fill_kind_type fill);
      sha1_pkg::req_type item;
      bit                bursty;
      bursty = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < body_words; i++) begin
         item.data_word  = fill_word(fill);
         item.byte_count = 3'($urandom_range(0, 7));
         item.last       = 1'b0;
         send_request(item, bursty ? 0 : $urandom_range(0, MAX_GAP));
      end
      item.data_word  = fill_word(fill);
      item.byte_count = tail_count;
      item.last       = 1'b1;
      send_request(item, bursty ? 0 : $urandom_range(0, MAX_GAP));
   endtask

   // Sender stops and lets the hasher drain every owed digest.
   task automatic wait_for_digests();
      req_valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
   endtask

   // Receiver: random ready gaps per digest word, back-to-back runs for some
   // digests, and one long stall early on while the sender keeps going.
   initial begin
      int unsigned taken;
      int unsigned gap;
      bit          bursty;
      bit          held;
      taken  = 0;
      bursty = 1'b0;
      held   = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (taken % 5 == 0) bursty = ($urandom_range(0, 3) == 0);
         if (taken == HOLD_AFTER && !held) begin
            held = 1'b1;
            gap  = HOLD_CYCLES;
         end else begin
            gap = bursty ? 0 : $urandom_range(0, MAX_GAP);
         end
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         tracker.check_digest(rsp_data);
         taken++;
      end
   end

   initial begin
      int unsigned   random_base;
      int unsigned   body_words;
      int unsigned   pick;
      bit            paused;
      fill_kind_type fill;
      tracker = new();
      paused  = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty message, every tail count with ones below the valid
      // bytes, oversized counts that mean four bytes, a short zero message,
      // and a tail that leaves no room for the length and spills a block.
      send_message(0, 3'd0, FILL_RANDOM);
      for (int tc = 1; tc <= 4; tc++) send_message(0, 3'(tc), FILL_ONES);
      for (int tc = 5; tc <= 7; tc++) send_message(0, 3'(tc), FILL_RANDOM);
      send_message(1, 3'd4, FILL_ZERO);
      send_message(13, 3'd4, FILL_RANDOM);
      wait_for_digests();

      // Random messages. Most are up to 17 words long; some run to 41 words.
      random_base = requests_sent;
      while (requests_sent < random_base + RANDOM_ITEMS) begin
         if (!paused && requests_sent >= random_base + RANDOM_ITEMS / 2) begin
            paused = 1'b1;
            wait_for_digests();
         end
         body_words = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40)
                                                  : $urandom_range(0, 16);
         pick = $urandom_range(0, 19);
         fill = (pick == 0) ? FILL_ZERO : (pick == 1) ? FILL_ONES : FILL_RANDOM;
         send_message(body_words, 3'($urandom_range(0, 7)), fill);
      end

      wait_for_digests();
      // Extra time to catch any stray digest words.
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.pending() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

### files.f
rtl/core/sha1_pkg.sv
rtl/core/sha1_round.sv
rtl/core/sha1_hash.sv
rtl/core/sha1_chk.sv
bench/tb_top.sv
